// ===== rtl/core/fps_pkg.sv =====
// Shared types, constants and the four-point weighting function for the
// curve subdivider. No dependencies.
package fps_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int COORD_BITS = 24;
  localparam int SUM_BITS = COORD_BITS + 6;
  localparam int POINT_BITS = 3 * COORD_BITS;
  localparam int TDATA_BITS = ((POINT_BITS + 7) / 8) * 8;
  localparam int LEVEL_BITS = 3;

  // Emission kinds, one bit each, emitted lowest bit first.
  localparam logic [3:0] EMIT_MID1 = 4'b0001;
  localparam logic [3:0] EMIT_PASSC = 4'b0010;
  localparam logic [3:0] EMIT_MID2 = 4'b0100;
  localparam logic [3:0] EMIT_PASSX = 4'b1000;
  localparam logic [3:0] EMIT_NONE = 4'b0000;

  // Register indexes on the configuration port.
  localparam logic [2:0] ADDR_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] ADDR_METHOD_ENABLE = 3'd4;

  typedef logic [2:0][COORD_BITS-1:0] point_t;

  typedef struct packed {
    point_t pt;
    logic   last;
  } item_t;

  // Per coordinate: floor((-a + 9b + 9c - d) / 16), saturated.
  function automatic point_t four_point(point_t a, point_t b, point_t c, point_t d);
    logic signed [SUM_BITS-1:0] ea;
    logic signed [SUM_BITS-1:0] eb;
    logic signed [SUM_BITS-1:0] ec;
    logic signed [SUM_BITS-1:0] ed;
    logic signed [SUM_BITS-1:0] s;
    logic signed [SUM_BITS-1:0] q;
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    point_t r;
    hi = SUM_BITS'({1'b0, {(COORD_BITS - 1){1'b1}}});
    lo = -hi - SUM_BITS'(1);
    for (int k = 0; k < 3; k++) begin
      ea = SUM_BITS'(signed'(a[k]));
      eb = SUM_BITS'(signed'(b[k]));
      ec = SUM_BITS'(signed'(c[k]));
      ed = SUM_BITS'(signed'(d[k]));
      s = (eb <<< 3) + eb + (ec <<< 3) + ec - ea - ed;
      q = s >>> 4;
      if (q > hi) begin
        r[k] = hi[COORD_BITS-1:0];
      end else if (q < lo) begin
        r[k] = lo[COORD_BITS-1:0];
      end else begin
        r[k] = q[COORD_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fps_cell.sv =====
// One refinement level: a three-point window, fill count and an emission
// sequencer with an output register. Depends on fps_pkg.
module fps_cell import fps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  bypass,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  point_t w0, w1, w2;
  logic [1:0] fill;
  point_t ra, rb, rc, rx;
  logic rlast;
  logic [3:0] pend;
  logic ovalid;
  item_t odata;

  logic [3:0] sel;
  logic load;
  logic [3:0] pend_after;
  logic acc;
  logic [3:0] plan;
  item_t emit;
  point_t oa, ob, oc, od;

  assign sel = pend & (~pend + 4'd1);
  assign load = (pend != EMIT_NONE) && (!ovalid || out_ready);
  assign pend_after = load ? (pend & ~sel) : pend;
  assign in_ready = (pend_after == EMIT_NONE);
  assign acc = in_valid && in_ready;

  always_comb begin
    if (bypass || fill == 2'd0) begin
      plan = EMIT_PASSX;
    end else if (fill == 2'd1) begin
      plan = in_item.last ? (EMIT_MID2 | EMIT_PASSX) : EMIT_NONE;
    end else begin
      plan = EMIT_MID1 | EMIT_PASSC | (in_item.last ? (EMIT_MID2 | EMIT_PASSX) : EMIT_NONE);
    end
  end

  always_comb begin
    oa = ra;
    ob = rb;
    oc = rc;
    od = rx;
    emit.pt = rx;
    emit.last = 1'b0;
    case (sel)
      EMIT_MID1: begin
        emit.pt = four_point(oa, ob, oc, od);
      end
      EMIT_PASSC: begin
        emit.pt = rc;
      end
      EMIT_MID2: begin
        oa = rb;
        ob = rc;
        oc = rx;
        emit.pt = four_point(oa, ob, oc, od);
      end
      EMIT_PASSX: begin
        emit.last = rlast;
      end
      default: begin
        emit.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      pend <= EMIT_NONE;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        odata <= emit;
      end else if (out_ready) begin
        ovalid <= 1'b0;
      end
      if (acc) begin
        pend <= plan;
        ra <= (fill == 2'd2) ? w1 : w0;
        rb <= (fill == 2'd1) ? w2 : w1;
        rc <= w2;
        rx <= in_item.pt;
        rlast <= in_item.last;
        if (!bypass) begin
          if (in_item.last) begin
            fill <= 2'd0;
          end else begin
            w0 <= w1;
            w1 <= w2;
            w2 <= in_item.pt;
            fill <= (fill == 2'd3) ? 2'd3 : fill + 2'd1;
          end
        end
      end else begin
        pend <= pend_after;
      end
    end
  end

  assign out_valid = ovalid;
  assign out_item = odata;

  a_busy_blocks : assert property (@(posedge clk) disable iff (rst)
    ($countones(pend) >= 2) |-> !in_ready)
    else $error("cell accepted while several beats remained");
  a_bypass_plan : assert property (@(posedge clk) disable iff (rst)
    (acc && bypass) |=> (pend == EMIT_PASSX))
    else $error("bypassed item not planned as a single pass beat");
  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    (acc && !bypass && in_item.last) |=> (fill == 2'd0))
    else $error("fill not cleared after last point");
  a_out_holds : assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_ready) |=> (ovalid && $stable(odata)))
    else $error("stalled output beat changed");

endmodule

// ===== rtl/core/four_point_curve_subdivider_unit.sv =====
// Top level of the four-point curve subdivider: configuration registers and
// a chain of refinement cells. Depends on fps_pkg and fps_cell.

// Points stream in on the s_ group and refined points leave on the m_ group.
// Each refinement level is one cell of a chain; a cell takes one beat, emits
// between zero and four beats for it (one per cycle from its output register
// while the output is not stalled) and accepts its next beat in the cycle its
// last pending beat is loaded. With four levels a steady-state input point
// yields sixteen output points, so the output port sets how often input beats
// are taken; the last cell's single output beat per cycle, when not stalled,
// is the limit. Levels beyond level_count pass beats through unchanged. When
// method_enable is 0 or level_count is 0, input beats are taken every cycle
// and dropped. Write the registers only while the chain is empty.
module four_point_curve_subdivider_unit import fps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,  // px, py, pz from bit 0 up
  input  logic                  s_tlast,  // curve_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,  // qx, qy, qz from bit 0 up
  output logic                  m_tlast   // out_last
);

  logic [LEVEL_BITS-1:0] level_count;
  logic method_enable;
  logic [LEVEL_BITS-1:0] eff_levels;
  logic active;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_BITS'(1);
      method_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_LEVEL_COUNT: level_count <= pwdata[LEVEL_BITS-1:0];
        ADDR_METHOD_ENABLE: method_enable <= pwdata[0];
        default: level_count <= level_count;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LEVEL_COUNT: prdata = 32'(level_count);
      ADDR_METHOD_ENABLE: prdata = 32'(method_enable);
      default: prdata = 32'd0;
    endcase
  end

  // Counts above the number of cells act as the full chain.
  assign eff_levels = (level_count > LEVEL_BITS'(MAX_LEVELS)) ?
                      LEVEL_BITS'(MAX_LEVELS) : level_count;
  assign active = method_enable && (eff_levels != '0);

  logic  valid_c [MAX_LEVELS+1];
  logic  ready_c [MAX_LEVELS+1];
  item_t item_c  [MAX_LEVELS+1];

  assign valid_c[0] = s_tvalid && active;
  assign item_c[0].pt = s_tdata[POINT_BITS-1:0];
  assign item_c[0].last = s_tlast;
  assign s_tready = active ? ready_c[0] : 1'b1;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    fps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bypass   (eff_levels <= LEVEL_BITS'(i)),
      .in_valid (valid_c[i]),
      .in_ready (ready_c[i]),
      .in_item  (item_c[i]),
      .out_valid(valid_c[i+1]),
      .out_ready(ready_c[i+1]),
      .out_item (item_c[i+1])
    );
  end

  assign m_tvalid = valid_c[MAX_LEVELS];
  assign ready_c[MAX_LEVELS] = m_tready;
  assign m_tdata = TDATA_BITS'(item_c[MAX_LEVELS].pt);
  assign m_tlast = item_c[MAX_LEVELS].last;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for four_point_curve_subdivider_unit: streams open
// polylines in, predicts the refined points and checks every output beat.
// Depends on fps_pkg and the RTL of the subdivider.

module tb;
  import fps_pkg::*;

  // One point as it travels on either stream, coordinates signed.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         last;
  } curve_pt_t;

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_BITS-1:0] s_tdata = '0;  // px, py, pz from bit 0 up
  logic                  s_tlast = 1'b0;  // curve_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;  // qx, qy, qz from bit 0 up
  logic                  m_tlast;  // out_last

  four_point_curve_subdivider_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copies of the configuration and the per-level refinement state.
  int unsigned cfg_levels = 1;
  logic        cfg_enable = 1'b1;
  logic [1:0]  lvl_fill [MAX_LEVELS];
  curve_pt_t   lvl_win [MAX_LEVELS][3];

  curve_pt_t   pending_pts [$];   // points waiting to be driven
  curve_pt_t   refined_pts [$];   // refined points expected on the output
  curve_pt_t   stage_in [$];
  curve_pt_t   stage_out [$];

  int          errors = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b0;
  int          rdy_mode = 0;
  int          rdy_phase = 0;
  int          idle_cycles = 0;

  // One coordinate of the inserted point: floor((-a + 9b + 9c - d) / 16),
  // saturated back to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] weigh(
      logic signed [COORD_BITS-1:0] a, logic signed [COORD_BITS-1:0] b,
      logic signed [COORD_BITS-1:0] c, logic signed [COORD_BITS-1:0] d);
    logic signed [COORD_BITS+7:0] s;
    logic signed [COORD_BITS+7:0] q;
    s = 9 * (COORD_BITS+8)'(b) + 9 * (COORD_BITS+8)'(c)
        - (COORD_BITS+8)'(a) - (COORD_BITS+8)'(d);
    q = s >>> 4;
    if (q > (COORD_BITS+8)'(CMAX)) return CMAX;
    if (q < (COORD_BITS+8)'(CMIN)) return CMIN;
    return q[COORD_BITS-1:0];
  endfunction

  function automatic curve_pt_t midpoint(curve_pt_t a, curve_pt_t b, curve_pt_t c,
                                         curve_pt_t d);
    curve_pt_t m;
    m.x = weigh(a.x, b.x, c.x, d.x);
    m.y = weigh(a.y, b.y, c.y, d.y);
    m.z = weigh(a.z, b.z, c.z, d.z);
    m.last = 1'b0;
    return m;
  endfunction

  // Feeds one point into level lv and appends what that level emits.
  // The window holds the three most recent points, oldest in slot 0.
  function automatic void refine_level(int lv, curve_pt_t p);
    logic [1:0] f;
    curve_pt_t  w0, w1, w2, keep;
    f = lvl_fill[lv];
    w0 = lvl_win[lv][0];
    w1 = lvl_win[lv][1];
    w2 = lvl_win[lv][2];
    if (f == 0) begin
      stage_out = {stage_out, p};
    end else if (f == 1) begin
      // Second point of the curve: a midpoint is only known once it ends.
      if (p.last) begin
        stage_out = {stage_out, midpoint(w2, w2, p, p)};
        stage_out = {stage_out, p};
      end
    end else begin
      // The point before b is clamped to the curve's first point early on.
      stage_out = {stage_out, midpoint((f == 2) ? w1 : w0, w1, w2, p)};
      keep = w2;
      keep.last = 1'b0;
      stage_out = {stage_out, keep};
      if (p.last) begin
        stage_out = {stage_out, midpoint(w1, w2, p, p)};
        stage_out = {stage_out, p};
      end
    end
    if (p.last) begin
      lvl_fill[lv] = 0;
    end else begin
      lvl_win[lv][0] = w1;
      lvl_win[lv][1] = w2;
      lvl_win[lv][2] = p;
      lvl_fill[lv] = (f < 3) ? f + 2'd1 : 2'd3;
    end
  endfunction

  // Runs one accepted beat through the active levels and queues the results.
  // Skipped levels keep their state untouched.
  function automatic void predict_refined(curve_pt_t p);
    int n;
    n = (cfg_levels > MAX_LEVELS) ? MAX_LEVELS : cfg_levels;
    if (!cfg_enable || n == 0) return;
    stage_in.delete();
    stage_in = {stage_in, p};
    for (int lv = 0; lv < n; lv++) begin
      stage_out.delete();
      foreach (stage_in[i]) refine_level(lv, stage_in[i]);
      stage_in = stage_out;
    end
    refined_pts = {refined_pts, stage_in};
  endfunction

  task automatic report_mismatch(string what, logic [COORD_BITS-1:0] got,
                                 logic [COORD_BITS-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: sends pending points in bursts of random length, with gaps when sender_gaps is set.
  always @(posedge clk) begin
    curve_pt_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        p = pending_pts.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= TDATA_BITS'({p.z, p.y, p.x});
        s_tlast <= p.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left = sender_gaps ? $urandom_range(1, 6) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure; the pattern changes from phase to phase.
  always @(posedge clk) begin
    rdy_phase++;
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (rdy_phase % 5) < 3;
      default: m_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Monitor: predicts on every input beat and checks every output beat.
  // Prediction comes first so that an expectation is always in place.
  always @(posedge clk) begin
    curve_pt_t inp, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        inp.x = s_tdata[COORD_BITS-1:0];
        inp.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
        inp.z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        inp.last = s_tlast;
        predict_refined(inp);
      end
      if (m_tvalid && m_tready) begin
        if (refined_pts.size() == 0) begin
          $display("unexpected output beat %h at %0t", m_tdata, $realtime);
          errors++;
        end else begin
          want = refined_pts.pop_front();
          if (m_tdata[COORD_BITS-1:0] !== want.x)
            report_mismatch("qx", m_tdata[COORD_BITS-1:0], want.x);
          if (m_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
            report_mismatch("qy", m_tdata[2*COORD_BITS-1:COORD_BITS], want.y);
          if (m_tdata[3*COORD_BITS-1:2*COORD_BITS] !== want.z)
            report_mismatch("qz", m_tdata[3*COORD_BITS-1:2*COORD_BITS], want.z);
          if (m_tlast !== want.last)
            report_mismatch("out_last", COORD_BITS'(m_tlast), COORD_BITS'(want.last));
        end
      end
    end
  end

  // Watchdog: only counts while work is outstanding and nothing moves.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_pts.size() == 0 && refined_pts.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LEVEL_COUNT) cfg_levels = data[2:0];
    else if (addr == ADDR_METHOD_ENABLE) cfg_enable = data[0];
  endtask

  // Waits until the sender is empty and every expected beat has come, then
  // lets the chain settle in case the last beats caused no output.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pts.size() > 0 || s_tvalid || refined_pts.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic curve_pt_t make_pt(logic signed [COORD_BITS-1:0] x,
      logic signed [COORD_BITS-1:0] y, logic signed [COORD_BITS-1:0] z, logic last);
    curve_pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    return p;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int style,
      logic signed [COORD_BITS-1:0] base);
    case (style)
      0: return COORD_BITS'($urandom());
      1: return base + COORD_BITS'($signed($urandom_range(0, 4095)) - 2048);
      default: begin
        case ($urandom_range(0, 3))
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Queues a curve; with terminate clear it stays open for the next phase.
  function automatic void add_curve(int len, bit terminate);
    int style;
    logic signed [COORD_BITS-1:0] bx, by, bz;
    style = ($urandom_range(0, 9) < 3) ? 0 : (($urandom_range(0, 9) < 8) ? 1 : 2);
    bx = COORD_BITS'($urandom());
    by = COORD_BITS'($urandom());
    bz = COORD_BITS'($urandom());
    for (int i = 0; i < len; i++) begin
      bx = rand_coord(style, bx);
      by = rand_coord(style, by);
      bz = rand_coord(style, bz);
      pending_pts = {pending_pts, make_pt(bx, by, bz, terminate && (i == len - 1))};
    end
  endfunction

  initial begin
    int lvl_plan [8] = '{4, 2, 0, 3, 1, 5, 4, 7};
    int sent;
    for (int lv = 0; lv < MAX_LEVELS; lv++) lvl_fill[lv] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting of one level.
    pending_pts = {pending_pts, make_pt(CMAX, CMIN, '0, 1'b1)};         // single point
    pending_pts = {pending_pts, make_pt(CMIN, CMAX, '1, 1'b0)};         // two points
    pending_pts = {pending_pts, make_pt(CMAX, CMIN, 24'sd256, 1'b1)};
    // Alternating extremes drive the weighted sum past both limits.
    for (int i = 0; i < 6; i++)
      pending_pts = {pending_pts, i[0] ? make_pt(CMIN, CMAX, CMIN, i == 5)
                                       : make_pt(CMAX, CMIN, CMAX, 1'b0)};
    pending_pts = {pending_pts, make_pt(24'sd100, -24'sd100, 24'sd1, 1'b0)};
    pending_pts = {pending_pts, make_pt(24'sd200, -24'sd300, -24'sd1, 1'b0)};
    pending_pts = {pending_pts, make_pt(24'sd400, 24'sd0, 24'sd7, 1'b1)};
    wait_drained();
    reg_write(ADDR_LEVEL_COUNT, 32'd4);
    pending_pts = {pending_pts, make_pt(CMAX, CMAX, CMIN, 1'b1)};
    pending_pts = {pending_pts, make_pt(CMAX, CMAX, CMAX, 1'b0)};
    pending_pts = {pending_pts, make_pt(CMIN, CMIN, CMIN, 1'b1)};
    add_curve(4, 1'b1);
    wait_drained();

    // Random phases; some end with a curve left open so that levels pick up
    // mid-curve after the setting changes.
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(ADDR_LEVEL_COUNT, lvl_plan[ph]);
      reg_write(ADDR_METHOD_ENABLE, (ph == 6) ? 32'd0 : 32'd1);
      rdy_mode = ph % 4;
      sender_gaps = ph[0];
      sent = 0;
      while (sent < 55) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
        add_curve(len, 1'b1);
        sent += len;
      end
      if (ph % 3 == 1) add_curve($urandom_range(1, 4), 1'b0);
      wait_drained();
    end
    reg_write(ADDR_METHOD_ENABLE, 32'd1);
    reg_write(ADDR_LEVEL_COUNT, 32'd4);
    add_curve(3, 1'b1);
    wait_drained();

    if (errors == 0 && refined_pts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fps_pkg.sv
rtl/core/fps_cell.sv
rtl/core/four_point_curve_subdivider_unit.sv
dv/tb.sv
